@@ rtl/core/running_median_insert_delete_macros.svh @@
// Assertion macros shared by the running median checker.
`ifndef RUNNING_MEDIAN_INSERT_DELETE_MACROS_SVH
`define RUNNING_MEDIAN_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RMID_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("running median check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RMID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("running median check failed");

`endif

@@ rtl/core/rmid_pkg.sv @@
// Shared types and constants for the running median block.
package rmid_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W      = 32;
	localparam int MED_W        = 33;
	localparam int STATUS_W     = 2;

	// Operation codes on the op field
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_WRONG = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Update command broadcast to every cell
	typedef struct packed {
		logic add_en;
		logic del_en;
	} rmid_cmd_t;

endpackage

@@ rtl/core/rmid_cell.sv @@
// One cell of the sorted chain: holds one value and shifts with its neighbors.
module rmid_cell
	import rmid_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int INDEX    = 0,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rmid_cmd_t                 cmd,
	input  logic signed [VALUE_W-1:0] key,
	input  logic [CNT_W-1:0]          count,
	input  logic signed [VALUE_W-1:0] left_val,
	input  logic                      left_occ,
	input  logic                      left_gt,
	input  logic signed [VALUE_W-1:0] right_val,
	input  logic                      right_occ,
	output logic signed [VALUE_W-1:0] val,
	output logic                      occ,
	output logic                      gt,
	output logic                      eq,
	output logic [VALUE_W-1:0]        lo_term,
	output logic [VALUE_W-1:0]        hi_term
);

	localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
	localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

	logic signed [VALUE_W-1:0] val_q;
	logic                      occ_q;
	logic [CNT_W-1:0]          half;
	logic                      lo_sel;
	logic                      hi_sel;

	assign val = val_q;
	assign occ = occ_q;
	assign gt  = occ_q && (val_q > key);
	assign eq  = occ_q && (val_q == key);

	// Payload: insert shifts right of the insertion point, delete shifts left
	always_ff @(posedge clk) begin
		if (cmd.add_en) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (occ_q ? (val_q > key) : left_occ) begin
				val_q <= key;
			end
		end else if (cmd.del_en && occ_q && (val_q >= key)) begin
			val_q <= right_val;
		end
	end

	// Occupancy follows the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.add_en) begin
			occ_q <= occ_q | left_occ;
		end else if (cmd.del_en && occ_q && (val_q >= key)) begin
			occ_q <= right_occ;
		end
	end

	// Middle-cell select: odd count uses the center twice
	assign half    = count >> 1;
	assign hi_sel  = (IDX == half);
	assign lo_sel  = count[0] ? (IDX == half) : (IDX_P1 == half);
	assign lo_term = lo_sel ? val_q : '0;
	assign hi_term = hi_sel ? val_q : '0;

endmodule

@@ rtl/core/running_median_insert_delete.sv @@
// Running median over a sorted chain of cells: the top level.
//
// Each transaction adds a value or removes one copy of it; the block answers
// with twice the median (sum of the two middle values for an even count) and
// a status. Values sit in a row of CAPACITY cells kept in ascending order; an
// add or remove compares the key in every cell at once and shifts the row at
// the accepting edge. In the report state that follows, the middle cells are
// picked by count and added into the output register, which offers the result;
// the input takes no new transaction until that result is loaded.
// in_ready is low in the report state, which lasts for as long as an
// earlier result still waits on out_ready; a new transaction can be taken
// while a result waits. No clearing pass after reset: only the occupancy
// flags are reset, and they say which cells hold data.
module running_median_insert_delete
	import rmid_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [MED_W-1:0]   median_twice,
	output logic [STATUS_W-1:0]       status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	typedef enum logic {ST_IDLE, ST_REPORT} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	status_t                   pend_status_q;
	logic                      out_valid_q;
	logic signed [MED_W-1:0]   median_q;
	status_t                   status_q;

	logic signed [VALUE_W-1:0] cell_val [CAPACITY];
	logic                      cell_occ [CAPACITY];
	logic                      cell_gt  [CAPACITY];
	logic                      cell_eq  [CAPACITY];
	logic [VALUE_W-1:0]        cell_lo  [CAPACITY];
	logic [VALUE_W-1:0]        cell_hi  [CAPACITY];

	logic                      accept;
	logic                      full;
	logic                      found;
	logic                      load_out;
	rmid_cmd_t                 cmd;
	status_t                   next_status;
	logic [VALUE_W-1:0]        lo_or;
	logic [VALUE_W-1:0]        hi_or;
	logic signed [MED_W-1:0]   median_sum;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CNT_FULL);
	assign load_out  = (state_q == ST_REPORT) && (!out_valid_q || out_ready);

	// Any cell holding the key
	always_comb begin
		found = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			found = found | cell_eq[i];
		end
	end

	assign cmd.add_en = accept && (op == OP_ADD) && !full;
	assign cmd.del_en = accept && (op == OP_REMOVE) && found;

	// Status decided at accept time
	always_comb begin
		if (op == OP_ADD) begin
			next_status = full ? STATUS_FULL : STATUS_OK;
		end else if (!found || (count_q == CNT_ONE)) begin
			next_status = STATUS_WRONG;
		end else begin
			next_status = STATUS_OK;
		end
	end

	// Row of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VALUE_W-1:0] l_val;
		logic                      l_occ;
		logic                      l_gt;
		logic signed [VALUE_W-1:0] r_val;
		logic                      r_occ;

		if (g == 0) begin : g_first
			assign l_val = '0;
			assign l_occ = 1'b1;
			assign l_gt  = 1'b0;
		end else begin : g_mid
			assign l_val = cell_val[g-1];
			assign l_occ = cell_occ[g-1];
			assign l_gt  = cell_gt[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign r_val = '0;
			assign r_occ = 1'b0;
		end else begin : g_inner
			assign r_val = cell_val[g+1];
			assign r_occ = cell_occ[g+1];
		end

		rmid_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.key       (value),
			.count     (count_q),
			.left_val  (l_val),
			.left_occ  (l_occ),
			.left_gt   (l_gt),
			.right_val (r_val),
			.right_occ (r_occ),
			.val       (cell_val[g]),
			.occ       (cell_occ[g]),
			.gt        (cell_gt[g]),
			.eq        (cell_eq[g]),
			.lo_term   (cell_lo[g]),
			.hi_term   (cell_hi[g])
		);
	end

	// Gather the two middle values
	always_comb begin
		lo_or = '0;
		hi_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			lo_or = lo_or | cell_lo[i];
			hi_or = hi_or | cell_hi[i];
		end
	end

	assign median_sum = $signed({lo_or[VALUE_W-1], lo_or})
		+ $signed({hi_or[VALUE_W-1], hi_or});

	// Control, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			pend_status_q <= STATUS_OK;
			out_valid_q   <= 1'b0;
			median_q      <= '0;
			status_q      <= STATUS_OK;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pend_status_q <= next_status;
						if (cmd.add_en) begin
							count_q <= count_q + CNT_ONE;
						end else if (cmd.del_en) begin
							count_q <= count_q - CNT_ONE;
						end
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					if (load_out) begin
						status_q    <= pend_status_q;
						median_q    <= (pend_status_q == STATUS_WRONG) ? '0 : median_sum;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign median_twice = median_q;
	assign status       = status_q;

endmodule

@@ rtl/core/rmid_checker.sv @@
// Port-level checks for the running median block, bound to the top level.
`include "running_median_insert_delete_macros.svh"

module rmid_checker
	import rmid_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [MED_W-1:0]   median_twice,
	input logic [STATUS_W-1:0]       status
);

	// Held result stays put until taken
	`RMID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(median_twice) && $stable(status))

	// Only the defined status codes appear
	`RMID_ASSERT_NOW(a_status_code, out_valid, status == STATUS_OK || status == STATUS_WRONG || status == STATUS_FULL)

	// A wrong transaction reports a zero median
	`RMID_ASSERT_NOW(a_wrong_zero, out_valid && (status == STATUS_WRONG), median_twice == '0)

	// One transaction in the cell row at a time
	`RMID_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind running_median_insert_delete rmid_checker u_rmid_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.median_twice (median_twice),
	.status       (status)
);
